[src/lzwcsc_pkg.sv]
// lzwcsc_pkg: item types, controller states and control structs for the
// lzw code size counter. No dependencies.
package lzwcsc_pkg;

    // command field codes
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // width and saturation constants of the fixed fields
    localparam int          MIN_CODE_LEN  = 8;
    localparam int          HIST_DEPTH    = 256;
    localparam logic [4:0]  WIDTH_RESET   = 5'd12;
    localparam logic [39:0] BITS_MAX      = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] CNT_MAX       = 32'hFFFF_FFFF;

    // register index of code_width
    localparam logic REG_CODE_WIDTH = 1'b0;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } lzw_in_t;

    typedef struct packed {
        logic        code_valid;
        logic [15:0] code;
        logic [4:0]  code_length;
        logic [39:0] total_bits;
        logic [31:0] byte_count;
        logic [31:0] total_bytes;
    } lzw_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_UPDATE
    } lzwcsc_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic probe_rd;
        logic check;
        logic commit;
    } lzwcsc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_probe;
        logic probe_done;
        logic out_free;
    } lzwcsc_sts_t;

endpackage

[src/lzwcsc_ctrl.sv]
// lzwcsc_ctrl: sequencer for table clearing, dictionary probing and commit.
// Depends on lzwcsc_pkg.
module lzwcsc_ctrl
    import lzwcsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  lzwcsc_sts_t sts,
    output lzwcsc_cmd_t cmd
);

    lzwcsc_state_t state_reg;
    lzwcsc_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.need_probe ? ST_PROBE : ST_UPDATE;
                end
            end
            ST_PROBE:
            begin
                cmd.probe_rd = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.probe_done ? ST_UPDATE : ST_PROBE;
            end
            ST_UPDATE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[src/lzwcsc_dp.sv]
// lzwcsc_dp: hashed dictionary, byte histogram, counters and result register.
// Depends on lzwcsc_pkg.
module lzwcsc_dp
    import lzwcsc_pkg::*;
#(
    parameter int MAX_CODE_BITS = 16,
    parameter int HASH_SLOTS    = 131072
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lzwcsc_cmd_t cmd,
    output lzwcsc_sts_t sts,
    input  lzw_in_t     in_data,
    input  logic [4:0]  code_width,
    output logic        out_valid,
    input  logic        out_stall,
    output lzw_out_t    out_data
);

    localparam int HASH_W = $clog2(HASH_SLOTS);
    localparam int KEY_W  = MAX_CODE_BITS + 8;
    localparam int NFOLD  = (KEY_W + HASH_W - 1) / HASH_W;
    localparam int CNT_W  = MAX_CODE_BITS + 1;

    typedef struct packed {
        logic                     used;
        logic [KEY_W-1:0]         key;
        logic [MAX_CODE_BITS-1:0] code;
    } entry_t;

    // fold the key into a slot index
    function automatic logic [HASH_W-1:0] hash_idx(input logic [KEY_W-1:0] key);
        logic [NFOLD*HASH_W-1:0] pad;
        logic [HASH_W-1:0]       h;
        logic [HASH_W:0]         he;
        pad = (NFOLD*HASH_W)'(key);
        h   = '0;
        for (int i = 0; i < NFOLD; i++)
        begin
            h = h ^ pad[i*HASH_W +: HASH_W];
        end
        he = {1'b0, h};
        if (he >= (HASH_W+1)'(HASH_SLOTS))
        begin
            he = he - (HASH_W+1)'(HASH_SLOTS);
        end
        return he[HASH_W-1:0];
    endfunction

    entry_t      dict_mem [HASH_SLOTS];
    logic [31:0] hist_mem [HIST_DEPTH];

    logic [HASH_W-1:0]        clr_idx_reg;
    logic [HASH_W-1:0]        idx_reg;
    logic [HASH_W-1:0]        pcnt_reg;
    logic                     cmd_reg;
    logic [7:0]               byte_reg;
    entry_t                   rd_reg;
    logic [31:0]              hist_rd_reg;
    logic                     hit_reg;
    logic                     slot_ok_reg;
    logic [MAX_CODE_BITS-1:0] found_reg;
    logic [CNT_W-1:0]         next_code_reg;
    logic [MAX_CODE_BITS-1:0] prefix_reg;
    logic                     present_reg;
    logic [39:0]              bit_total_reg;
    logic [31:0]              byte_total_reg;
    logic                     out_valid_reg;
    lzw_out_t                 out_data_reg;

    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  in_key;
    logic [4:0]        w_eff;
    logic [4:0]        len;
    logic [CNT_W-1:0]  limit;
    logic              is_data;
    logic              do_insert;
    logic              charge;
    logic [39:0]       bits_new;
    logic [31:0]       hist_new;
    logic [31:0]       bytes_new;
    logic              last_slot;
    entry_t            new_entry;

    // key of the pending pair and of an arriving byte
    assign key    = {prefix_reg, byte_reg};
    assign in_key = {prefix_reg, in_data.data_byte};

    // effective width, charge and capacity
    assign w_eff = (code_width > 5'(MAX_CODE_BITS)) ? 5'(MAX_CODE_BITS) : code_width;
    assign len   = (w_eff < 5'(MIN_CODE_LEN)) ? 5'(MIN_CODE_LEN) : w_eff;
    assign limit = CNT_W'(1) << w_eff;

    assign is_data   = (cmd_reg == CMD_DATA);
    assign last_slot = (idx_reg == HASH_W'(HASH_SLOTS - 1));
    assign do_insert = cmd.commit && is_data && present_reg && !hit_reg
                     && (next_code_reg < limit) && slot_ok_reg;
    assign charge    = !is_data || (present_reg && !hit_reg);
    assign bits_new  = (bit_total_reg > (BITS_MAX - 40'(len))) ? BITS_MAX
                     : bit_total_reg + 40'(len);
    assign hist_new  = (hist_rd_reg == CNT_MAX) ? CNT_MAX : hist_rd_reg + 32'd1;
    assign bytes_new = (byte_total_reg == CNT_MAX) ? CNT_MAX : byte_total_reg + 32'd1;

    assign new_entry.used = 1'b1;
    assign new_entry.key  = key;
    assign new_entry.code = next_code_reg[MAX_CODE_BITS-1:0];

    // status
    assign sts.clear_last = (clr_idx_reg == HASH_W'(HASH_SLOTS - 1));
    assign sts.need_probe = (in_data.command == CMD_DATA) && present_reg;
    assign sts.probe_done = !rd_reg.used || (rd_reg.key == key)
                          || (pcnt_reg == HASH_W'(HASH_SLOTS - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // dictionary memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            dict_mem[clr_idx_reg] <= '0;
        end
        else if (do_insert)
        begin
            dict_mem[idx_reg] <= new_entry;
        end
        if (cmd.probe_rd)
        begin
            rd_reg <= dict_mem[idx_reg];
        end
    end

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr && (clr_idx_reg < HASH_W'(HIST_DEPTH)))
        begin
            hist_mem[clr_idx_reg[7:0]] <= '0;
        end
        else if (cmd.commit && is_data)
        begin
            hist_mem[byte_reg] <= hist_new;
        end
        if (cmd.accept)
        begin
            hist_rd_reg <= hist_mem[in_data.data_byte];
        end
    end

    // item capture and probe walk
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg     <= in_data.command;
            byte_reg    <= in_data.data_byte;
            idx_reg     <= hash_idx(in_key);
            pcnt_reg    <= '0;
            hit_reg     <= 1'b0;
            slot_ok_reg <= 1'b0;
            found_reg   <= '0;
        end
        else if (cmd.check)
        begin
            if (!rd_reg.used)
            begin
                slot_ok_reg <= 1'b1;
            end
            else if (rd_reg.key == key)
            begin
                hit_reg   <= 1'b1;
                found_reg <= rd_reg.code;
            end
            else
            begin
                idx_reg  <= last_slot ? '0 : idx_reg + HASH_W'(1);
                pcnt_reg <= pcnt_reg + HASH_W'(1);
            end
        end
    end

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_idx_reg <= clr_idx_reg + HASH_W'(1);
        end
    end

    // stream state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_code_reg  <= CNT_W'(256);
            prefix_reg     <= '0;
            present_reg    <= 1'b0;
            bit_total_reg  <= '0;
            byte_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (charge)
            begin
                bit_total_reg <= bits_new;
            end
            if (do_insert)
            begin
                next_code_reg <= next_code_reg + CNT_W'(1);
            end
            if (!is_data)
            begin
                prefix_reg  <= '0;
                present_reg <= 1'b0;
            end
            else
            begin
                byte_total_reg <= bytes_new;
                present_reg    <= 1'b1;
                prefix_reg     <= hit_reg ? found_reg : MAX_CODE_BITS'(byte_reg);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg.code_valid  <= present_reg && (!is_data || !hit_reg);
            out_data_reg.code        <= (present_reg && (!is_data || !hit_reg))
                                        ? 16'(prefix_reg) : 16'd0;
            out_data_reg.code_length <= len;
            out_data_reg.total_bits  <= charge ? bits_new : bit_total_reg;
            out_data_reg.byte_count  <= is_data ? hist_new : 32'd0;
            out_data_reg.total_bytes <= is_data ? bytes_new : byte_total_reg;
        end
    end

endmodule

[src/lzw_code_size_counter.sv]
// lzw_code_size_counter: top level with the code_width register.
// Depends on lzwcsc_pkg, lzwcsc_ctrl and lzwcsc_dp.

// LZW compressor that reports each emitted code and running size counts, one
// result per input item. After reset the block sweeps its dictionary table and
// histogram, one entry a cycle, before it takes the first item. An end command
// or the first byte after one skips the dictionary search and waits only for
// the result register; a byte that searches the dictionary probes its slots one
// at a time (usually one or two) through the single read port of the
// dictionary memory.
// A new item is taken while the previous result still waits to be taken.
module lzw_code_size_counter
    import lzwcsc_pkg::*;
#(
    parameter int MAX_CODE_BITS = 16,
    parameter int HASH_SLOTS    = 131072
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  lzw_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output lzw_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  code_width_reg;
    lzwcsc_cmd_t cmd;
    lzwcsc_sts_t sts;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_width_reg <= WIDTH_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_CODE_WIDTH))
        begin
            code_width_reg <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CODE_WIDTH) ? {27'd0, code_width_reg} : 32'd0;

    lzwcsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lzwcsc_dp #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .HASH_SLOTS    (HASH_SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (in_data),
        .code_width (code_width_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

[src/lzwcsc_chk.sv]
// lzwcsc_chk: port-level checks on the result channel, bound to the top level.
// Depends on lzwcsc_pkg.
module lzwcsc_chk
    import lzwcsc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     out_valid,
    input logic     out_stall,
    input lzw_out_t out_data
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result item changed");

    // charged length stays in range
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.code_length >= 5'd8) && (out_data.code_length <= 5'd20))
        else $error("code length out of range");

    // a byte count never exceeds the total byte count
    a_hist_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.byte_count <= out_data.total_bytes)
        else $error("byte count above total bytes");

    // an emitted code has been charged
    a_code_charged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.code_valid |-> out_data.total_bits >= 40'(out_data.code_length))
        else $error("emitted code not charged");

endmodule

bind lzw_code_size_counter lzwcsc_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[test/tb_top.sv]
// tb_top: self-checking testbench for lzw_code_size_counter.
// Depends on lzwcsc_pkg and the lzw_code_size_counter RTL.
module tb_top;
    import lzwcsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    lzw_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    lzw_out_t    out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [15:0] dict_map [int];
    int unsigned entry_next;
    logic [15:0] prefix;
    logic        has_prefix;
    logic [31:0] hist [256];
    logic [39:0] bits_sum;
    logic [31:0] bytes_sum;
    logic [4:0]  width_reg;

    lzw_out_t    expected_codes [$];
    int          fail_count;
    int          items_sent;
    int          codes_seen;
    int          quiet_cycles;
    bit          idle_on;
    int          hold_req;

    lzw_code_size_counter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // saturating add of one code charge
    function automatic logic [39:0] add_bits(logic [39:0] acc, logic [4:0] len);
        if (acc > BITS_MAX - 40'(len))
            return BITS_MAX;
        return acc + 40'(len);
    endfunction

    // compute the result of one accepted item and advance the predictor
    function automatic lzw_out_t lzw_predict(lzw_in_t it);
        lzw_out_t    r;
        int unsigned w;
        int unsigned limit;
        int          key;
        w = (width_reg > 5'd16) ? 16 : width_reg;
        limit = 1 << w;
        r = '0;
        r.code_length = (w < MIN_CODE_LEN) ? 5'(MIN_CODE_LEN) : 5'(w);
        if (it.command == CMD_END)
        begin
            if (has_prefix)
            begin
                r.code_valid = 1'b1;
                r.code = prefix;
            end
            bits_sum = add_bits(bits_sum, r.code_length);
            has_prefix = 1'b0;
            prefix = '0;
        end
        else
        begin
            if (!has_prefix)
            begin
                prefix = {8'd0, it.data_byte};
                has_prefix = 1'b1;
            end
            else
            begin
                key = {prefix, it.data_byte};
                if (dict_map.exists(key))
                    prefix = dict_map[key];
                else
                begin
                    r.code_valid = 1'b1;
                    r.code = prefix;
                    bits_sum = add_bits(bits_sum, r.code_length);
                    if (entry_next < limit)
                    begin
                        dict_map[key] = 16'(entry_next);
                        entry_next++;
                    end
                    prefix = {8'd0, it.data_byte};
                end
            end
            if (hist[it.data_byte] != CNT_MAX)
                hist[it.data_byte]++;
            r.byte_count = hist[it.data_byte];
            if (bytes_sum != CNT_MAX)
                bytes_sum++;
        end
        r.total_bits = bits_sum;
        r.total_bytes = bytes_sum;
        return r;
    endfunction

    // offer one item and predict its result once it is taken
    task automatic send_item(logic cmd, logic [7:0] b);
        lzw_in_t it;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        it.command = cmd;
        it.data_byte = b;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        expected_codes.push_back(lzw_predict(it));
        items_sent++;
        @(negedge clk);
    endtask

    // wait until every expected result has come
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // register write, setup then access
    task automatic write_width(logic [4:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(REG_CODE_WIDTH) << 2;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        width_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // random stream: bytes from a small alphabet plus noise and occasional end commands
    task automatic random_stream(int n);
        logic [7:0] base;
        int         i;
        base = 8'($urandom);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 40) == 0)
                send_item(CMD_END, 8'($urandom));
            else if ($urandom_range(0, 9) == 0)
                send_item(CMD_DATA, 8'($urandom));
            else
                send_item(CMD_DATA, base ^ 8'($urandom_range(0, 3)));
        end
    endtask

    // extremes of the byte field, end with and without a prefix
    task automatic test_directed();
        send_item(CMD_END, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_END, 8'h00);
        send_item(CMD_END, 8'hAA);
        send_item(CMD_DATA, 8'h55);
        send_item(CMD_DATA, 8'hAA);
        send_item(CMD_END, 8'h00);
    endtask

    // tiny, full and oversized widths, including capacity exhaustion
    task automatic test_widths();
        logic [4:0] widths [7] = '{5'd0, 5'd1, 5'd8, 5'd9, 5'd16, 5'd17, 5'd31};
        foreach (widths[k])
        begin
            write_width(widths[k]);
            random_stream(widths[k] == 5'd9 ? 200 : 60);
        end
        write_width(WIDTH_RESET);
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        hold_req = 300;
        random_stream(100);
        drain();
        random_stream(50);
    endtask

    task automatic test_random();
        random_stream(500);
        write_width(5'd10);
        random_stream(200);
        idle_on = 1'b0;
        write_width(5'd12);
        random_stream(150);
    endtask

    // receiver stall: random bursts and a long requested hold
    initial
    begin
        int hold;
        out_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 10);
            else
                out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        lzw_out_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            codes_seen++;
            if (expected_codes.size() == 0)
            begin
                $error("unexpected result item %p", out_data);
                fail_count++;
            end
            else
            begin
                exp_r = expected_codes.pop_front();
                if (out_data.code_valid !== exp_r.code_valid)
                begin
                    $error("code_valid exp %0d got %0d", exp_r.code_valid,
                           out_data.code_valid);
                    fail_count++;
                end
                if (out_data.code !== exp_r.code)
                begin
                    $error("code exp %0d got %0d", exp_r.code, out_data.code);
                    fail_count++;
                end
                if (out_data.code_length !== exp_r.code_length)
                begin
                    $error("code_length exp %0d got %0d", exp_r.code_length,
                           out_data.code_length);
                    fail_count++;
                end
                if (out_data.total_bits !== exp_r.total_bits)
                begin
                    $error("total_bits exp %0d got %0d", exp_r.total_bits,
                           out_data.total_bits);
                    fail_count++;
                end
                if (out_data.byte_count !== exp_r.byte_count)
                begin
                    $error("byte_count exp %0d got %0d", exp_r.byte_count,
                           out_data.byte_count);
                    fail_count++;
                end
                if (out_data.total_bytes !== exp_r.total_bytes)
                begin
                    $error("total_bytes exp %0d got %0d", exp_r.total_bytes,
                           out_data.total_bytes);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake, clearing pass included
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lzw_code_size_counter: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        entry_next = 256;
        prefix = '0;
        has_prefix = 1'b0;
        foreach (hist[i])
            hist[i] = '0;
        bits_sum = '0;
        bytes_sum = '0;
        width_reg = WIDTH_RESET;
        fail_count = 0;
        items_sent = 0;
        codes_seen = 0;
        quiet_cycles = 0;
        idle_on = 1'b1;
        hold_req = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_widths();
        test_backpressure();
        test_random();
        drain();

        $display("covered %0d items, %0d results, widths 0 to 31, dictionary fill",
                 items_sent, codes_seen);
        if (fail_count == 0)
            $display("lzw_code_size_counter: match");
        else
            $display("lzw_code_size_counter: mismatch");
        $finish;
    end
endmodule

[files.f]
src/lzwcsc_pkg.sv
src/lzwcsc_ctrl.sv
src/lzwcsc_dp.sv
src/lzw_code_size_counter.sv
src/lzwcsc_chk.sv
test/tb_top.sv
